[src/assert_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");

`endif

[src/msvs_pkg.sv]
package msvs_pkg;

   localparam int unsigned IN_W      = 24;
   localparam int unsigned OUT_W     = 25;
   localparam int unsigned THR_W     = 32;
   localparam logic [31:0] THR_RESET = 32'd42950;
   localparam int unsigned Q32_W     = 48;
   localparam int unsigned WIDE_RW   = 50;
   localparam int unsigned NARROW_RW = 32;

   typedef struct packed {
      logic [48:0] sum_ac;
      logic [47:0] max_ac;
      logic        ortho;
      logic        diag;
      logic [23:0] diag_res;
   } side_type;

   typedef struct packed {
      logic        diag;
      logic [23:0] diag_res;
   } tail_type;

   localparam int unsigned SIDE_W = $bits(side_type);
   localparam int unsigned TAIL_W = $bits(tail_type);

endpackage

[src/msvs_sqrt_cell.sv]
module msvs_sqrt_cell
   import msvs_pkg::*;
#(
   parameter int unsigned RW = 32,
   parameter int unsigned PW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_rad,
   input  logic [RW+1:0]     in_rem,
   input  logic [RW-1:0]     in_root,
   input  logic [PW-1:0]     in_side,
   output logic              out_valid,
   output logic [2*RW-1:0]   out_rad,
   output logic [RW+1:0]     out_rem,
   output logic [RW-1:0]     out_root,
   output logic [PW-1:0]     out_side
);

   logic              valid_ff;
   logic [2*RW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [PW-1:0]     side_ff;
   logic [RW+1:0]     shifted;
   logic [RW+1:0]     trial;
   logic              take;

   always_comb begin
      shifted = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
      trial   = {in_root, 2'b01};
      take    = shifted >= trial;
      rem_in  = take ? shifted - trial : shifted;
      root_in = {in_root[RW-2:0], take};
      rad_in  = {in_rad[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

[src/matrix2x2_max_singular_value_top.sv]
// Channel   | Ports                                 | Handshake
// request   | start, busy, req_scale_x..req_scale_y | taken when start and not busy
// response  | rsp_valid, rsp_max_scale              | one-cycle strobe, no back-pressure
// config    | csr_valid, csr_ready, csr_wdata       | taken when valid and ready
//
// One item can be accepted every cycle while busy is low; each item passes
// through nine register stages plus two chains of square-root cells, 50 for
// the discriminant root and 32 for the final root, one bit per cell.
// Synchronous reset clears all valid flags and loads the threshold default.
// The receiver cannot stall, so busy is high only during reset.
`include "assert_macros.svh"

module matrix2x2_max_singular_value_top
   import msvs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [IN_W-1:0]  req_scale_x,
   input  logic signed [IN_W-1:0]  req_shear_y,
   input  logic signed [IN_W-1:0]  req_shear_x,
   input  logic signed [IN_W-1:0]  req_scale_y,
   output logic                    rsp_valid,
   output logic [OUT_W-1:0]        rsp_max_scale,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [THR_W-1:0]        csr_wdata
);

   logic [THR_W-1:0] thr_ff;

   logic                   v1_ff;
   logic signed [IN_W-1:0] xx_ff, xy_ff, yx_ff, yy_ff;

   logic                v2_ff;
   logic signed [47:0]  pxx_ff, pxy_ff, pyx_ff, pyy_ff, pb1_ff, pb2_ff;
   logic                diag2_ff, diag2_in;
   logic [23:0]         dres2_ff, dres2_in;
   logic [23:0]         ax, ay;

   logic                v3_ff;
   logic [47:0]         a3_ff, c3_ff;
   logic signed [48:0]  b3_ff;
   logic                diag3_ff;
   logic [23:0]         dres3_ff;

   logic                v4_ff;
   logic [47:0]         bm4_ff, bm4_in, dm4_ff, dm4_in;
   side_type            side4_ff, side4_in;

   logic                v5_ff;
   logic [47:0]         dll_ff, dlh_ff, dhh_ff, bll_ff, blh_ff, bhh_ff;
   side_type            side5_ff, side5_in;

   logic                v6_ff;
   logic [95:0]         d2_ff, d2_in, b2_ff, b2_in;
   side_type            side6_ff;

   logic                v7_ff;
   logic [99:0]         disc_ff, disc_in;
   side_type            side7_ff;

   logic                      wv   [0:WIDE_RW];
   logic [2*WIDE_RW-1:0]      wrad [0:WIDE_RW];
   logic [WIDE_RW+1:0]        wrem [0:WIDE_RW];
   logic [WIDE_RW-1:0]        wrt  [0:WIDE_RW];
   logic [SIDE_W-1:0]         wsd  [0:WIDE_RW];
   side_type                  wend;

   logic                      v8_ff;
   logic [63:0]               rad8_ff, rad8_in;
   tail_type                  tail8_ff, tail8_in;
   logic [50:0]               hsum;

   logic                      nv   [0:NARROW_RW];
   logic [2*NARROW_RW-1:0]    nrad [0:NARROW_RW];
   logic [NARROW_RW+1:0]      nrem [0:NARROW_RW];
   logic [NARROW_RW-1:0]      nrt  [0:NARROW_RW];
   logic [TAIL_W-1:0]         nsd  [0:NARROW_RW];
   tail_type                  nend;

   logic                      v9_ff;
   logic [OUT_W-1:0]          res9_ff, res9_in;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_comb begin
      ax       = xx_ff[IN_W-1] ? 24'(-xx_ff) : 24'(xx_ff);
      ay       = yy_ff[IN_W-1] ? 24'(-yy_ff) : 24'(yy_ff);
      diag2_in = (xy_ff == '0) && (yx_ff == '0);
      dres2_in = (ax > ay) ? ax : ay;
   end

   always_comb begin
      bm4_in = b3_ff[48] ? 48'(-b3_ff) : b3_ff[47:0];
      dm4_in = (a3_ff > c3_ff) ? a3_ff - c3_ff : c3_ff - a3_ff;
      side4_in.sum_ac   = 49'(a3_ff) + 49'(c3_ff);
      side4_in.max_ac   = (a3_ff > c3_ff) ? a3_ff : c3_ff;
      side4_in.ortho    = 1'b0;
      side4_in.diag     = diag3_ff;
      side4_in.diag_res = dres3_ff;
   end

   always_comb begin
      side5_in       = side4_ff;
      side5_in.ortho = bm4_ff <= 48'(thr_ff);
   end

   always_comb begin
      d2_in   = (96'(dhh_ff) << 48) + (96'(dlh_ff) << 25) + 96'(dll_ff);
      b2_in   = (96'(bhh_ff) << 48) + (96'(blh_ff) << 25) + 96'(bll_ff);
      disc_in = 100'(d2_ff) + (100'(b2_ff) << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_wdata;
         end
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= wv[WIDE_RW];
         v9_ff <= nv[NARROW_RW];
      end

      xx_ff <= req_scale_x;
      xy_ff <= req_shear_y;
      yx_ff <= req_shear_x;
      yy_ff <= req_scale_y;

      pxx_ff   <= xx_ff * xx_ff;
      pxy_ff   <= xy_ff * xy_ff;
      pyx_ff   <= yx_ff * yx_ff;
      pyy_ff   <= yy_ff * yy_ff;
      pb1_ff   <= xx_ff * yx_ff;
      pb2_ff   <= yy_ff * xy_ff;
      diag2_ff <= diag2_in;
      dres2_ff <= dres2_in;

      a3_ff    <= 48'(pxx_ff) + 48'(pxy_ff);
      c3_ff    <= 48'(pyx_ff) + 48'(pyy_ff);
      b3_ff    <= {pb1_ff[47], pb1_ff} + {pb2_ff[47], pb2_ff};
      diag3_ff <= diag2_ff;
      dres3_ff <= dres2_ff;

      bm4_ff   <= bm4_in;
      dm4_ff   <= dm4_in;
      side4_ff <= side4_in;

      dll_ff   <= dm4_ff[23:0] * dm4_ff[23:0];
      dlh_ff   <= dm4_ff[23:0] * dm4_ff[47:24];
      dhh_ff   <= dm4_ff[47:24] * dm4_ff[47:24];
      bll_ff   <= bm4_ff[23:0] * bm4_ff[23:0];
      blh_ff   <= bm4_ff[23:0] * bm4_ff[47:24];
      bhh_ff   <= bm4_ff[47:24] * bm4_ff[47:24];
      side5_ff <= side5_in;

      d2_ff    <= d2_in;
      b2_ff    <= b2_in;
      side6_ff <= side5_ff;

      disc_ff  <= disc_in;
      side7_ff <= side6_ff;

      rad8_ff  <= rad8_in;
      tail8_ff <= tail8_in;

      res9_ff  <= res9_in;
   end

   assign wv[0]   = v7_ff;
   assign wrad[0] = disc_ff;
   assign wrem[0] = '0;
   assign wrt[0]  = '0;
   assign wsd[0]  = side7_ff;

   for (genvar i = 0; i < WIDE_RW; i++) begin : g_wide
      msvs_sqrt_cell #(
         .RW (WIDE_RW),
         .PW (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (wv[i]),
         .in_rad    (wrad[i]),
         .in_rem    (wrem[i]),
         .in_root   (wrt[i]),
         .in_side   (wsd[i]),
         .out_valid (wv[i+1]),
         .out_rad   (wrad[i+1]),
         .out_rem   (wrem[i+1]),
         .out_root  (wrt[i+1]),
         .out_side  (wsd[i+1])
      );
   end

   always_comb begin
      wend              = side_type'(wsd[WIDE_RW]);
      hsum              = 51'(wend.sum_ac) + 51'(wrt[WIDE_RW]);
      rad8_in           = wend.ortho ? 64'(wend.max_ac) : 64'(hsum[50:1]);
      tail8_in.diag     = wend.diag;
      tail8_in.diag_res = wend.diag_res;
   end

   assign nv[0]   = v8_ff;
   assign nrad[0] = rad8_ff;
   assign nrem[0] = '0;
   assign nrt[0]  = '0;
   assign nsd[0]  = tail8_ff;

   for (genvar j = 0; j < NARROW_RW; j++) begin : g_narrow
      msvs_sqrt_cell #(
         .RW (NARROW_RW),
         .PW (TAIL_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (nv[j]),
         .in_rad    (nrad[j]),
         .in_rem    (nrem[j]),
         .in_root   (nrt[j]),
         .in_side   (nsd[j]),
         .out_valid (nv[j+1]),
         .out_rad   (nrad[j+1]),
         .out_rem   (nrem[j+1]),
         .out_root  (nrt[j+1]),
         .out_side  (nsd[j+1])
      );
   end

   always_comb begin
      nend    = tail_type'(nsd[NARROW_RW]);
      res9_in = nend.diag ? OUT_W'(nend.diag_res) : nrt[NARROW_RW][OUT_W-1:0];
   end

   assign rsp_valid     = v9_ff;
   assign rsp_max_scale = res9_ff;

   `AST_NEXT(a_accept_enters, clock, reset, start && !busy, v1_ff)
   `AST_SAME(a_result_range, clock, reset, rsp_valid, rsp_max_scale <= 25'd16777216)
   `AST_NEXT(a_wide_to_narrow, clock, reset, wv[WIDE_RW], v8_ff)
   `AST_NEXT(a_narrow_to_out, clock, reset, nv[NARROW_RW], rsp_valid)

endmodule

[tb/tb_matrix2x2_max_singular_value_top.sv]
`timescale 1ns / 1ps

module tb_matrix2x2_max_singular_value_top;
   import msvs_pkg::*;

   localparam int LATENCY = 91;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [IN_W-1:0] req_scale_x = '0;
   logic signed [IN_W-1:0] req_shear_y = '0;
   logic signed [IN_W-1:0] req_shear_x = '0;
   logic signed [IN_W-1:0] req_scale_y = '0;
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_max_scale;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THR_W-1:0] csr_wdata = '0;

   logic [THR_W-1:0] threshold;
   logic [OUT_W-1:0] expected_scales[$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   longint cycles = 0;

   matrix2x2_max_singular_value_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_scale_x(req_scale_x), .req_shear_y(req_shear_y),
      .req_shear_x(req_shear_x), .req_scale_y(req_scale_y),
      .rsp_valid(rsp_valid), .rsp_max_scale(rsp_max_scale),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         t = r | (64'd1 << bit_pos);
         if ({64'd0, t} * {64'd0, t} <= d) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] max_singular_value(
         input logic signed [23:0] xx, input logic signed [23:0] xy,
         input logic signed [23:0] yx, input logic signed [23:0] yy);
      longint sxx, sxy, syx, syy, a, c, b, bm, dm, s;
      logic [127:0] disc;
      logic [63:0] h;
      sxx = xx;
      sxy = xy;
      syx = yx;
      syy = yy;
      if (xy == 0 && yx == 0) begin
         a = sxx < 0 ? -sxx : sxx;
         c = syy < 0 ? -syy : syy;
         return OUT_W'((a > c) ? a : c);
      end
      a = sxx * sxx + sxy * sxy;
      c = syx * syx + syy * syy;
      b = sxx * syx + syy * sxy;
      bm = b < 0 ? -b : b;
      if (bm <= longint'(threshold)) begin
         return OUT_W'(floor_sqrt(128'((a > c) ? a : c)));
      end
      dm = a > c ? a - c : c - a;
      disc = 128'(dm) * 128'(dm) + 4 * (128'(bm) * 128'(bm));
      s = floor_sqrt(disc);
      h = 64'(a + c + s) >> 1;
      return OUT_W'(floor_sqrt(128'(h)));
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_scales.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_max_scale));
         end else if (expected_scales[0] !== rsp_max_scale) begin
            report_mismatch($sformatf("max_scale got %0d want %0d",
                                      rsp_max_scale, expected_scales[0]));
            void'(expected_scales.pop_front());
         end else begin
            void'(expected_scales.pop_front());
         end
      end
   end

   task automatic send_matrix(input logic [23:0] xx, input logic [23:0] xy,
                              input logic [23:0] yx, input logic [23:0] yy,
                              input bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_scale_x <= xx;
      req_shear_y <= xy;
      req_shear_x <= yx;
      req_scale_y <= yy;
      do @(posedge clock); while (busy);
      expected_scales.push_back(max_singular_value(xx, xy, yx, yy));
      items_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_scales.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] random_entry();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'h800000;
         2: return 24'h7FFFFF;
         3: return 24'(int'($urandom_range(0, 1023)) - 512);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_matrix(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
      send_matrix(24'h800000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
      send_matrix(24'h7FFFFF, 24'h000000, 24'h000000, 24'h800000, 1'b0);
      send_matrix(24'hFFFFFF, 24'h000000, 24'h000000, 24'h010000, 1'b0);
      send_matrix(24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_matrix(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_matrix(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
      send_matrix(24'h010000, 24'h000001, 24'h000000, 24'h010000, 1'b0);
      send_matrix(24'h010000, 24'h000000, 24'h000001, 24'h010000, 1'b0);
      send_matrix(24'h010000, 24'h010000, 24'hFF0000, 24'h010000, 1'b0);
      send_matrix(24'h020000, 24'h010000, 24'h010000, 24'h030000, 1'b0);
      send_matrix(24'h000000, 24'h000001, 24'h000000, 24'h000000, 1'b0);
      send_matrix(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0);
      send_matrix(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
      drain();
   endtask

   task automatic test_random(input int count, input bit gaps);
      for (int i = 0; i < count; i++) begin
         send_matrix(random_entry(), random_entry(), random_entry(),
                     random_entry(), gaps && ($urandom_range(0, 3) != 0));
         if (i == count / 2) begin
            drain();
         end
      end
      drain();
   endtask

   task automatic test_thresholds();
      write_threshold(32'd0);
      test_random(80, 1'b1);
      write_threshold(32'hFFFFFFFF);
      send_matrix(24'h010000, 24'h010000, 24'hFF0000, 24'h010000, 1'b0);
      send_matrix(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
      test_random(80, 1'b1);
      write_threshold($urandom);
      test_random(80, 1'b0);
      write_threshold(32'd42950);
      test_random(80, 1'b1);
   endtask

   initial begin
      threshold = THR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 1'b1);
      test_thresholds();
      drain();
      $display("Sent %0d matrices, checked %0d results over four threshold settings,",
               items_sent, results_seen);
      $display("covering diagonal, orthogonal and full eigenvalue paths.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/msvs_pkg.sv
src/msvs_sqrt_cell.sv
src/matrix2x2_max_singular_value_top.sv
tb/tb_matrix2x2_max_singular_value_top.sv
